// ===== rtl/mcfe_pkg.sv =====
// Shared types and constants of the motor command frame encoder.
`timescale 1ns / 1ps

package mcfe_pkg;

  // Stage load enables that the top level hands to every lane.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } mcfe_adv_t;

  // Field widths of one command.
  localparam int unsigned IdW  = 11;
  localparam int unsigned PosW = 17;
  localparam int unsigned VelW = 14;
  localparam int unsigned KpW  = 16;
  localparam int unsigned KdW  = 16;
  localparam int unsigned TrqW = 16;

  // Code widths.
  localparam int unsigned PosCodeW = 16;
  localparam int unsigned SetCodeW = 12;

  // Protocol ranges in the input fixed-point units.
  localparam int PosLo = -51200;
  localparam int PosHi = 51200;
  localparam int VelLo = -4160;
  localparam int VelHi = 4160;
  localparam int KpLo  = 0;
  localparam int KpHi  = 32000;
  localparam int KdLo  = 0;
  localparam int KdHi  = 20480;
  localparam int TrqLo = -18432;
  localparam int TrqHi = 18432;

  // Each span is split into a power of two and an odd divisor:
  // span = 2^Shift * Div. Recip sets the reciprocal precision.
  localparam int unsigned PosShift = 12;
  localparam int unsigned PosDiv   = 25;
  localparam int unsigned PosRecip = 21;
  localparam int unsigned VelShift = 7;
  localparam int unsigned VelDiv   = 65;
  localparam int unsigned VelRecip = 19;
  localparam int unsigned KpShift  = 8;
  localparam int unsigned KpDiv    = 125;
  localparam int unsigned KpRecip  = 19;
  localparam int unsigned KdShift  = 12;
  localparam int unsigned KdDiv    = 5;
  localparam int unsigned KdRecip  = 15;
  localparam int unsigned TrqShift = 12;
  localparam int unsigned TrqDiv   = 9;
  localparam int unsigned TrqRecip = 16;

  // Stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 80;

endpackage

// ===== rtl/motor_command_frame_encoder.sv =====
// Top level of the motor command frame encoder: stage control and frame packing.
`timescale 1ns / 1ps

// The block turns one motor command into one 8-byte command frame.
// The slave channel (s_axis_*) carries one command item: a motor id and five
// signed fixed-point set values. The master channel (m_axis_*) carries one
// frame item: the frame id, equal to the motor id, and the eight frame bytes.
// Each set value is saturated to its protocol range and scaled to an unsigned
// code; position takes 16 bits, the other four values take 12 bits.
// The datapath is a four-stage pipeline: clamp and offset, scale by the full
// code, reciprocal multiply, remainder correction. A command passes the stage
// registers in order, and its frame is presented on the master channel from the
// last one, v4_q; a receiver that is not ready can hold it in any stage.
// One item can be accepted in every cycle while m_axis_tready_i is high, so
// the sustained rate is one item per cycle. The reciprocal multiply stage,
// about 21 by 17 bits on the position lane, sets the clock period.
// Reset empties the pipeline; the data registers hold no reset value.
// When the receiver holds m_axis_tready_i low, the filled stages hold their
// items and the bubbles ahead of them keep closing, so s_axis_tready_o drops
// only once all four stages hold an item. No item is lost or repeated.

module motor_command_frame_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // From bit 0: motor_id[10:0], position[27:11], velocity[41:28],
  // stiffness[57:42], damping[73:58], torque[89:74], zero padding.
  input  logic [mcfe_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // From bit 0: frame_id[10:0], byte0[18:11], byte1[26:19], byte2[34:27],
  // byte3[42:35], byte4[50:43], byte5[58:51], byte6[66:59], byte7[74:67],
  // zero padding.
  output logic [mcfe_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned PosOff = mcfe_pkg::IdW;
  localparam int unsigned VelOff = PosOff + mcfe_pkg::PosW;
  localparam int unsigned KpOff  = VelOff + mcfe_pkg::VelW;
  localparam int unsigned KdOff  = KpOff + mcfe_pkg::KpW;
  localparam int unsigned TrqOff = KdOff + mcfe_pkg::KdW;
  localparam int unsigned PadW   = mcfe_pkg::OutDataW - mcfe_pkg::IdW - 64;

  mcfe_pkg::mcfe_adv_t adv;

  logic v1_q, v2_q, v3_q, v4_q;
  logic [mcfe_pkg::IdW-1:0] id1_q, id2_q, id3_q, id4_q;

  logic [mcfe_pkg::PosCodeW-1:0] pos_code;
  logic [mcfe_pkg::SetCodeW-1:0] vel_code, kp_code, kd_code, trq_code;

  // A stage may load when it is empty or its item moves on in this cycle.
  assign adv.s4 = !v4_q || m_axis_tready_i;
  assign adv.s3 = !v3_q || adv.s4;
  assign adv.s2 = !v2_q || adv.s3;
  assign adv.s1 = !v1_q || adv.s2;

  assign s_axis_tready_o = adv.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (adv.s2) begin
        v2_q <= v1_q;
      end
      if (adv.s3) begin
        v3_q <= v2_q;
      end
      if (adv.s4) begin
        v4_q <= v3_q;
      end
    end
  end

  // The motor id travels alongside the lanes unchanged.
  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      id1_q <= s_axis_tdata_i[mcfe_pkg::IdW-1:0];
    end
    if (adv.s2) begin
      id2_q <= id1_q;
    end
    if (adv.s3) begin
      id3_q <= id2_q;
    end
    if (adv.s4) begin
      id4_q <= id3_q;
    end
  end

  mcfe_lane #(
    .X_W      (mcfe_pkg::PosW),
    .LO       (mcfe_pkg::PosLo),
    .HI       (mcfe_pkg::PosHi),
    .CODE_W   (mcfe_pkg::PosCodeW),
    .SHIFT    (mcfe_pkg::PosShift),
    .DIVISOR  (mcfe_pkg::PosDiv),
    .RECIP_SH (mcfe_pkg::PosRecip)
  ) u_pos (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (s_axis_tdata_i[PosOff +: mcfe_pkg::PosW]),
    .code_o (pos_code)
  );

  mcfe_lane #(
    .X_W      (mcfe_pkg::VelW),
    .LO       (mcfe_pkg::VelLo),
    .HI       (mcfe_pkg::VelHi),
    .CODE_W   (mcfe_pkg::SetCodeW),
    .SHIFT    (mcfe_pkg::VelShift),
    .DIVISOR  (mcfe_pkg::VelDiv),
    .RECIP_SH (mcfe_pkg::VelRecip)
  ) u_vel (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (s_axis_tdata_i[VelOff +: mcfe_pkg::VelW]),
    .code_o (vel_code)
  );

  mcfe_lane #(
    .X_W      (mcfe_pkg::KpW),
    .LO       (mcfe_pkg::KpLo),
    .HI       (mcfe_pkg::KpHi),
    .CODE_W   (mcfe_pkg::SetCodeW),
    .SHIFT    (mcfe_pkg::KpShift),
    .DIVISOR  (mcfe_pkg::KpDiv),
    .RECIP_SH (mcfe_pkg::KpRecip)
  ) u_kp (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (s_axis_tdata_i[KpOff +: mcfe_pkg::KpW]),
    .code_o (kp_code)
  );

  mcfe_lane #(
    .X_W      (mcfe_pkg::KdW),
    .LO       (mcfe_pkg::KdLo),
    .HI       (mcfe_pkg::KdHi),
    .CODE_W   (mcfe_pkg::SetCodeW),
    .SHIFT    (mcfe_pkg::KdShift),
    .DIVISOR  (mcfe_pkg::KdDiv),
    .RECIP_SH (mcfe_pkg::KdRecip)
  ) u_kd (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (s_axis_tdata_i[KdOff +: mcfe_pkg::KdW]),
    .code_o (kd_code)
  );

  mcfe_lane #(
    .X_W      (mcfe_pkg::TrqW),
    .LO       (mcfe_pkg::TrqLo),
    .HI       (mcfe_pkg::TrqHi),
    .CODE_W   (mcfe_pkg::SetCodeW),
    .SHIFT    (mcfe_pkg::TrqShift),
    .DIVISOR  (mcfe_pkg::TrqDiv),
    .RECIP_SH (mcfe_pkg::TrqRecip)
  ) u_trq (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (s_axis_tdata_i[TrqOff +: mcfe_pkg::TrqW]),
    .code_o (trq_code)
  );

  // The frame is pure wiring of the registered codes: byte0 holds the
  // position high byte, and the 12-bit codes share the nibble bytes.
  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {
    {PadW{1'b0}},
    trq_code[7:0],
    kd_code[3:0], trq_code[11:8],
    kd_code[11:4],
    kp_code[7:0],
    vel_code[3:0], kp_code[11:8],
    vel_code[11:4],
    pos_code[7:0],
    pos_code[15:8],
    id4_q
  };

endmodule

// ===== rtl/mcfe_lane.sv =====
// One set-value lane: clamp, scale by the full code and divide by the span.
`timescale 1ns / 1ps

module mcfe_lane #(
  parameter int unsigned X_W      = 16,
  parameter int          LO       = 0,
  parameter int          HI       = 32000,
  parameter int unsigned CODE_W   = 12,
  parameter int unsigned SHIFT    = 8,
  parameter int unsigned DIVISOR  = 125,
  parameter int unsigned RECIP_SH = 19
) (
  input  logic                    clk_i,
  input  mcfe_pkg::mcfe_adv_t     adv_i,
  input  logic signed [X_W-1:0]   x_i,
  output logic [CODE_W-1:0]       code_o
);

  localparam int unsigned SPAN  = HI - LO;
  localparam int unsigned D_W   = $clog2(SPAN + 1);
  localparam int unsigned N_W   = D_W + CODE_W;
  localparam int unsigned M_W   = N_W - SHIFT;
  localparam int unsigned RECIP = (2 ** RECIP_SH) / DIVISOR;
  localparam int unsigned R_W   = $clog2(RECIP + 1);
  localparam int unsigned P_W   = M_W + R_W;

  logic [D_W-1:0]    d_d, d_q;
  logic [N_W-1:0]    n_full;
  logic [M_W-1:0]    m_d, m2_q, m3_q;
  logic [P_W-1:0]    p_d, p_q;
  logic [CODE_W-1:0] q0;
  logic [M_W-1:0]    rem;
  logic [CODE_W-1:0] code_d, code_q;

  // Stage 1: saturate to the range and remove the offset.
  always_comb begin
    if ($signed(x_i) < LO) begin
      d_d = '0;
    end else if ($signed(x_i) > HI) begin
      d_d = D_W'(SPAN);
    end else begin
      d_d = D_W'(32'($signed(x_i)) - LO);
    end
  end

  // Stage 2: times (2^n - 1) as a shift and subtract, then drop the
  // power-of-two part of the span.
  assign n_full = {d_q, {CODE_W{1'b0}}} - N_W'(d_q);
  assign m_d    = n_full[N_W-1:SHIFT];

  // Stage 3: reciprocal multiply; the estimate is low by at most one.
  assign p_d = P_W'(m2_q) * P_W'(RECIP);

  // Stage 4: one correction step from the remainder.
  assign q0     = CODE_W'(p_q >> RECIP_SH);
  assign rem    = m3_q - M_W'(q0) * M_W'(DIVISOR);
  assign code_d = q0 + CODE_W'(rem >= M_W'(DIVISOR));

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      d_q <= d_d;
    end
    if (adv_i.s2) begin
      m2_q <= m_d;
    end
    if (adv_i.s3) begin
      p_q  <= p_d;
      m3_q <= m2_q;
    end
    if (adv_i.s4) begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

// ===== bench/motor_command_frame_encoder_tb.sv =====
// Self-checking stream testbench for the motor command frame encoder.
`timescale 1ns / 1ps

module motor_command_frame_encoder_tb;

  localparam int unsigned StallLimit = 2000;  // cycles without any item moving
  localparam int unsigned DrainWait  = 12;    // pipeline is four stages deep
  localparam int unsigned HoldOff    = 64;    // long receiver stall, fills the pipe
  localparam int unsigned PhaseLen   = 260;
  localparam int unsigned NumPhases  = 6;

  typedef struct packed {
    logic [mcfe_pkg::TrqW-1:0] torque;
    logic [mcfe_pkg::KdW-1:0]  damping;
    logic [mcfe_pkg::KpW-1:0]  stiffness;
    logic [mcfe_pkg::VelW-1:0] velocity;
    logic [mcfe_pkg::PosW-1:0] position;
    logic [mcfe_pkg::IdW-1:0]  motor_id;
  } command_t;

  typedef struct packed {
    logic [7:0][7:0]          bytes;
    logic [mcfe_pkg::IdW-1:0] frame_id;
  } frame_t;

  // Holds the frames that accepted commands must produce, in order.
  class frame_checker;
    frame_t      pending_frames[$];
    int unsigned errors;

    // Saturate to [lo, hi], then floor((x - lo) * full / (hi - lo)).
    function longint scale_code(longint x, longint lo, longint hi, longint full);
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return ((x - lo) * full) / (hi - lo);
    endfunction

    function frame_t encode_frame(command_t c);
      frame_t      f;
      logic [15:0] pos_code;
      logic [11:0] vel_code, kp_code, kd_code, trq_code;
      pos_code = 16'(scale_code(longint'($signed(c.position)), -51200, 51200, 65535));
      vel_code = 12'(scale_code(longint'($signed(c.velocity)), -4160, 4160, 4095));
      kp_code  = 12'(scale_code(longint'($signed(c.stiffness)), 0, 32000, 4095));
      kd_code  = 12'(scale_code(longint'($signed(c.damping)), 0, 20480, 4095));
      trq_code = 12'(scale_code(longint'($signed(c.torque)), -18432, 18432, 4095));
      f.frame_id = c.motor_id;
      f.bytes[0] = pos_code[15:8];
      f.bytes[1] = pos_code[7:0];
      f.bytes[2] = vel_code[11:4];
      f.bytes[3] = {vel_code[3:0], kp_code[11:8]};
      f.bytes[4] = kp_code[7:0];
      f.bytes[5] = kd_code[11:4];
      f.bytes[6] = {kd_code[3:0], trq_code[11:8]};
      f.bytes[7] = trq_code[7:0];
      return f;
    endfunction

    function void note_command(command_t c);
      pending_frames.push_back(encode_frame(c));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_frame(logic [mcfe_pkg::OutDataW-1:0] data);
      frame_t want;
      if (pending_frames.size() == 0) begin
        report($sformatf("frame %h arrived with no command pending", data));
        return;
      end
      want = pending_frames.pop_front();
      if (data[mcfe_pkg::IdW-1:0] !== want.frame_id)
        report($sformatf("frame_id got %h, expected %h", data[mcfe_pkg::IdW-1:0],
                         want.frame_id));
      for (int i = 0; i < 8; i++) begin
        if (data[mcfe_pkg::IdW+8*i +: 8] !== want.bytes[i])
          report($sformatf("byte%0d got %h, expected %h (frame_id %h)",
                           i, data[mcfe_pkg::IdW+8*i +: 8], want.bytes[i],
                           want.frame_id));
      end
      if (data[mcfe_pkg::OutDataW-1:mcfe_pkg::IdW+64] !== '0)
        report($sformatf("padding got %h, expected zero",
                         data[mcfe_pkg::OutDataW-1:mcfe_pkg::IdW+64]));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          s_valid;
  logic                          s_ready;
  logic [mcfe_pkg::InDataW-1:0]  s_data;
  logic                          m_valid;
  logic                          m_ready;
  logic [mcfe_pkg::OutDataW-1:0] m_data;

  frame_checker checker_h;
  bit           send_no_idle;
  bit           recv_no_idle;
  bit           hold_off_req;
  int unsigned  quiet_cycles;

  motor_command_frame_encoder u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #4 clk = ~clk;

  // Ends the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [mcfe_pkg::InDataW-1:0] pack_command(command_t c);
    logic [mcfe_pkg::InDataW-1:0] d;
    d = '0;
    d[$bits(command_t)-1:0] = c;
    return d;
  endfunction

  // A mix of whole-field values, in-range values and values near a range limit.
  function automatic longint draw_value(int unsigned w, longint lo, longint hi);
    longint v;
    case ($urandom_range(0, 3))
      0: begin
        v = longint'($urandom) & ((longint'(1) << w) - 1);
        if (v[w-1]) v = v - (longint'(1) << w);
      end
      3: v = (($urandom_range(0, 1) != 0) ? lo : hi) + longint'($urandom_range(0, 8)) - 4;
      default: v = lo + longint'($urandom_range(0, 32'(hi - lo)));
    endcase
    return v;
  endfunction

  // Offers one command and returns at the falling edge after it was taken.
  task automatic send_command(command_t c);
    int unsigned gap;
    gap = send_no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= pack_command(c);
    do @(posedge clk); while (!s_ready);
    checker_h.note_command(c);
    @(negedge clk);
  endtask

  task automatic send_fields(longint id, longint pos, longint vel, longint kp, longint kd,
                             longint trq);
    command_t c;
    c.motor_id  = id[mcfe_pkg::IdW-1:0];
    c.position  = pos[mcfe_pkg::PosW-1:0];
    c.velocity  = vel[mcfe_pkg::VelW-1:0];
    c.stiffness = kp[mcfe_pkg::KpW-1:0];
    c.damping   = kd[mcfe_pkg::KdW-1:0];
    c.torque    = trq[mcfe_pkg::TrqW-1:0];
    send_command(c);
  endtask

  task automatic send_random();
    send_fields($urandom_range(0, 2047),
                draw_value(mcfe_pkg::PosW, -51200, 51200),
                draw_value(mcfe_pkg::VelW, -4160, 4160),
                draw_value(mcfe_pkg::KpW, 0, 32000),
                draw_value(mcfe_pkg::KdW, 0, 20480),
                draw_value(mcfe_pkg::TrqW, -18432, 18432));
  endtask

  // Receiver: waits a drawn number of cycles before each frame, none in a
  // no-idle phase, or a long stretch when a hold-off is requested.
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        gap = HoldOff;
        hold_off_req = 1'b0;
      end else begin
        gap = recv_no_idle ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      checker_h.check_frame(m_data);
      @(negedge clk);
    end
  end

  initial begin
    checker_h    = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    s_valid      = 1'b0;
    s_data       = '0;
    m_ready      = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: zero, raw field extremes, exact range limits and one step
    // beyond or inside them, negative gains, alternating id bits.
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(2047, 65535, 8191, 32767, 32767, 32767);
    send_fields(0, -65536, -8192, -32768, -32768, -32768);
    send_fields(1, 51200, 4160, 32000, 20480, 18432);
    send_fields(2, -51200, -4160, 0, 0, -18432);
    send_fields(3, 51201, 4161, 32001, 20481, 18433);
    send_fields(4, -51201, -4161, -1, -1, -18433);
    send_fields(5, 51199, 4159, 31999, 20479, 18431);
    send_fields(6, -51199, -4159, 1, 1, -18431);
    send_fields(12'h555, 1, -1, 16000, 10240, -1);
    send_fields(12'h2AA, -1, 1, -32768, 32767, 1);
    send_fields(7, 25600, -2080, 100, -20480, 9216);

    // Random phases: mixed idling, one or both sides without idling, and one phase
    // where the receiver stalls long while commands keep coming.
    for (int p = 0; p < NumPhases; p++) begin
      send_no_idle = (p == 1) || (p == 3) || (p == 4);
      recv_no_idle = (p == 2) || (p == 3);
      if (p == 4) hold_off_req = 1'b1;
      repeat (PhaseLen) send_random();
    end
    s_valid <= 1'b0;

    while (checker_h.pending_frames.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (checker_h.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
